// ===== design/thpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thpd_pkg
// Types and constants shared by the two-header packet deframer.
// ----------------------------------------------------------------------------
package thpd_pkg;

  localparam logic [7:0]  START_SHORT     = 8'hC1;
  localparam logic [7:0]  START_LONG      = 8'hC2;
  localparam logic [15:0] HDR_SHORT       = 16'd3;
  localparam logic [15:0] HDR_LONG        = 16'd4;
  localparam logic [15:0] MAX_LEN_DEFAULT = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_START   = 3'd0,
    PH_SIZE_HI = 3'd1,
    PH_SIZE_LO = 3'd2,
    PH_CODE    = 3'd3,
    PH_BODY    = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_START = 2'd1,
    ERR_SIZE  = 2'd2
  } err_t;

  typedef struct packed {
    logic        valid;
    logic [7:0]  data;
    logic [7:0]  code;
    logic [15:0] len;
    logic        kind;
    logic        first;
    logic        last;
    err_t        err;
  } result_t;

endpackage
`default_nettype wire

// ===== design/thpd_parse.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thpd_parse
// Header parser and frame counter; produces at most one result per item.
// ----------------------------------------------------------------------------
module thpd_parse (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [7:0]       data_byte,
  input  wire logic             dg_last,
  input  wire logic [15:0]      max_len,
  output thpd_pkg::result_t     res
);

  thpd_pkg::phase_t phase_r, phase_nxt;
  logic             kind_r, kind_nxt;
  logic [15:0]      size_r, size_nxt;
  logic [15:0]      left_r, left_nxt;
  logic [7:0]       code_r, code_nxt;
  logic             disc_r, disc_nxt;

  logic [15:0]      hdr;
  logic [15:0]      size_lo;
  logic [15:0]      left_dec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= thpd_pkg::PH_START;
      kind_r  <= 1'b0;
      size_r  <= '0;
      left_r  <= '0;
      code_r  <= '0;
      disc_r  <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      size_r  <= size_nxt;
      left_r  <= left_nxt;
      code_r  <= code_nxt;
      disc_r  <= disc_nxt;
    end
  end

  assign hdr      = kind_r ? thpd_pkg::HDR_LONG : thpd_pkg::HDR_SHORT;
  assign size_lo  = size_r | {8'h00, data_byte};
  assign left_dec = left_r - 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    size_nxt  = size_r;
    left_nxt  = left_r;
    code_nxt  = code_r;
    disc_nxt  = disc_r;
    res       = '0;
    res.err   = thpd_pkg::ERR_NONE;

    if (disc_r) begin
      if (dg_last) begin
        disc_nxt  = 1'b0;
        phase_nxt = thpd_pkg::PH_START;
      end
    end else begin
      unique case (phase_r)
        thpd_pkg::PH_START: begin
          if (data_byte == thpd_pkg::START_SHORT) begin
            kind_nxt  = 1'b0;
            size_nxt  = '0;
            phase_nxt = thpd_pkg::PH_SIZE_LO;
          end else if (data_byte == thpd_pkg::START_LONG) begin
            kind_nxt  = 1'b1;
            size_nxt  = '0;
            phase_nxt = thpd_pkg::PH_SIZE_HI;
          end else begin
            res.valid = 1'b1;
            res.err   = thpd_pkg::ERR_START;
            disc_nxt  = !dg_last;
          end
        end
        thpd_pkg::PH_SIZE_HI: begin
          size_nxt  = {data_byte, 8'h00};
          phase_nxt = thpd_pkg::PH_SIZE_LO;
        end
        thpd_pkg::PH_SIZE_LO: begin
          size_nxt = size_lo;
          if (size_lo < hdr || size_lo > max_len) begin
            res.valid = 1'b1;
            res.len   = size_lo;
            res.kind  = kind_r;
            res.err   = thpd_pkg::ERR_SIZE;
            phase_nxt = thpd_pkg::PH_START;
            disc_nxt  = !dg_last;
          end else begin
            // code byte counts toward the bytes still to emit
            left_nxt  = size_lo - (hdr - 16'd1);
            phase_nxt = thpd_pkg::PH_CODE;
          end
        end
        thpd_pkg::PH_CODE: begin
          code_nxt  = data_byte;
          left_nxt  = left_dec;
          res.valid = 1'b1;
          res.data  = data_byte;
          res.code  = data_byte;
          res.len   = size_r;
          res.kind  = kind_r;
          res.first = 1'b1;
          res.last  = (left_dec == '0);
          phase_nxt = (left_dec == '0) ? thpd_pkg::PH_START : thpd_pkg::PH_BODY;
        end
        thpd_pkg::PH_BODY: begin
          left_nxt  = left_dec;
          res.valid = 1'b1;
          res.data  = data_byte;
          res.code  = code_r;
          res.len   = size_r;
          res.kind  = kind_r;
          res.last  = (left_dec == '0);
          if (left_dec == '0) begin
            phase_nxt = thpd_pkg::PH_START;
          end
        end
        default: begin
          phase_nxt = thpd_pkg::PH_START;
        end
      endcase
    end
  end

  a_frame_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == thpd_pkg::PH_CODE || phase_r == thpd_pkg::PH_BODY) |-> left_r != '0)
    else $error("frame byte count is zero inside a frame");

  a_discard_silent: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> !res.valid)
    else $error("result produced while dropping bytes");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.valid && res.last) |=> (phase_r == thpd_pkg::PH_START && !disc_r))
    else $error("frame did not close after its last byte");

  a_error_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.valid && res.err != thpd_pkg::ERR_NONE && !dg_last) |=> disc_r)
    else $error("error did not start dropping");

endmodule
`default_nettype wire

// ===== design/two_header_packet_deframer.sv =====
`default_nettype none
// Each result is captured in the output register in the cycle after its item
// is accepted. Throughput: one item per cycle unless the input is stalled; the
// parser and counter settle within that cycle, and a stalled consumer holding a
// result stalls the input. Start and size bytes give a result only on an error,
// dropped bytes give none. Reset (synchronous) empties the output register,
// returns the parser to awaiting a start byte and sets the size limit to 65535.
// ----------------------------------------------------------------------------
// two_header_packet_deframer
// Deframes a byte stream of 0xC1/0xC2 length-prefixed frames.
// ----------------------------------------------------------------------------
module two_header_packet_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_datagram_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic [7:0]       out_head_code,
  output logic [15:0]      out_frame_len,
  output logic             out_long_header,
  output logic             out_first_of_frame,
  output logic             out_last_of_frame,
  output logic [1:0]       out_error_code
);

  logic [15:0]       max_len_r;
  logic              out_valid_r;
  thpd_pkg::result_t res;
  thpd_pkg::result_t res_r;
  logic              step;

  assign in_stall = out_valid_r && out_stall;
  assign step     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= thpd_pkg::MAX_LEN_DEFAULT;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  thpd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_data_byte),
    .dg_last   (in_datagram_last),
    .max_len   (max_len_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!in_stall) begin
      out_valid_r <= step && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte           = res_r.data;
  assign out_head_code      = res_r.code;
  assign out_frame_len      = res_r.len;
  assign out_long_header    = res_r.kind;
  assign out_first_of_frame = res_r.first;
  assign out_last_of_frame  = res_r.last;
  assign out_error_code     = res_r.err;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

endmodule
`default_nettype wire
